@@ hw/rtl/gapq_pkg.sv @@
// Shared types and constants of the GOP-aware packet queue.
`default_nettype none
package gapq_pkg;
  localparam int DEPTH_DEF = 256;
  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam int CAP_BIT = 40;

  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_POP    = 3'd1;
  localparam logic [2:0] MODE_CLEAR  = 3'd2;
  localparam logic [2:0] MODE_INTR   = 3'd3;
  localparam logic [2:0] MODE_RESUME = 3'd4;

  localparam logic [2:0] CFG_MAX_PKTS  = 3'd0;
  localparam logic [2:0] CFG_MAX_BYTES = 3'd1;
  localparam logic [2:0] CFG_LIVE_MS   = 3'd2;
  localparam logic [2:0] CFG_TRIM_EN   = 3'd3;
  localparam logic [2:0] CFG_TB_NUM    = 3'd4;
  localparam logic [2:0] CFG_TB_DEN    = 3'd5;

  typedef struct packed {
    logic [31:0] tag;
    logic [23:0] size;
    logic        key;
    logic [47:0] ts;
    logic        ts_valid;
  } desc_t;
endpackage
`default_nettype wire

@@ hw/rtl/gapq_store.sv @@
// Descriptor memory: one write port, one registered read port with bypass.
`default_nettype none
module gapq_store #(
  parameter int DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire gapq_pkg::desc_t      wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output gapq_pkg::desc_t           rdata
);
  import gapq_pkg::*;

  desc_t mem [DEPTH];
  desc_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-address write forwarded to the read port
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ hw/rtl/gapq_rescale.sv @@
// Span rescale to ms: shift-add multiply, then restoring divide, rounded.
`default_nettype none
module gapq_rescale (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire signed [48:0] diff,
  input  wire [30:0]        num,
  input  wire [30:0]        den,
  output logic              done,
  output logic              neg,
  output logic [40:0]       mag
);
  import gapq_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_RND  = 2'd2;
  localparam logic [1:0] PH_DIV  = 2'd3;
  localparam logic [40:0] CAP = 41'd1 << CAP_BIT;

  logic [1:0]  ph_r, ph_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [90:0] acc_r, acc_nxt;
  logic [90:0] a_r, a_nxt;
  logic [40:0] b_r, b_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [40:0] q_r, q_nxt;
  logic        sticky_r, sticky_nxt;
  logic        neg_r, neg_nxt;
  logic [48:0] mag_in;
  logic [31:0] rem_sh;
  logic        ge;

  always_comb begin
    ph_nxt     = ph_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    acc_nxt    = acc_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    sticky_nxt = sticky_r;
    neg_nxt    = neg_r;
    mag_in     = diff[48] ? 49'(-diff) : 49'(diff);
    rem_sh     = {1'b0, rem_r} << 1 | 32'(acc_r[90]);
    ge         = rem_sh >= {1'b0, den};
    case (ph_r)
      PH_IDLE: begin
        if (start) begin
          neg_nxt = diff[48];
          a_nxt   = 91'(mag_in);
          b_nxt   = 41'({10'b0, num} * 41'(MS_PER_S));
          acc_nxt = '0;
          cnt_nxt = '0;
          ph_nxt  = PH_MUL;
        end
      end
      PH_MUL: begin
        if (b_r[0]) begin
          acc_nxt = acc_r + a_r;
        end
        a_nxt   = a_r << 1;
        b_nxt   = b_r >> 1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd40) begin
          ph_nxt = PH_RND;
        end
      end
      PH_RND: begin
        acc_nxt    = acc_r + 91'(den >> 1);
        cnt_nxt    = '0;
        rem_nxt    = '0;
        q_nxt      = '0;
        sticky_nxt = 1'b0;
        ph_nxt     = PH_DIV;
      end
      PH_DIV: begin
        rem_nxt    = ge ? 31'(rem_sh - {1'b0, den}) : rem_sh[30:0];
        acc_nxt    = acc_r << 1;
        sticky_nxt = sticky_r | q_r[40];
        q_nxt      = {q_r[39:0], ge};
        cnt_nxt    = cnt_r + 7'd1;
        if (cnt_r == 7'd90) begin
          ph_nxt   = PH_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    sticky_r <= sticky_nxt;
    neg_r    <= neg_nxt;
  end

  assign done = done_r;
  assign neg  = neg_r;
  assign mag  = (sticky_r || (q_r > CAP)) ? CAP : q_r;
endmodule
`default_nettype wire

@@ hw/rtl/gop_aware_packet_queue.sv @@
// GOP-aware packet descriptor queue: top level with control sequencer.
// Pop, clear, interrupt, resume, unknown-mode and halted commands end with a span read; when the span
//   must be rescaled they also wait on the rescaler (41 multiply + 91 divide steps).
// Push also drops packets as the limits demand and runs at most one rescale per trim check.
// One command at a time: busy stays high until the result word is strobed.
// Reset clears pointers, counters and halt flag and sets config to its defaults; memory contents stay undefined.
`default_nettype none
module gop_aware_packet_queue #(
  parameter int DEPTH = gapq_pkg::DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire [2:0]                    in_mode,
  input  wire [31:0]                   in_pkt_tag,
  input  wire [23:0]                   in_pkt_size,
  input  wire                          in_pkt_is_key,
  input  wire signed [47:0]            in_pres_time,
  input  wire                          in_pres_time_valid,
  input  wire signed [47:0]            in_dec_time,
  input  wire                          in_dec_time_valid,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [2:0]                    cfg_index,
  input  wire [31:0]                   cfg_data,
  output logic                         out_valid,
  output logic                         out_ok,
  output logic [31:0]                  out_tag,
  output logic [23:0]                  out_size,
  output logic                         out_is_key,
  output logic signed [47:0]           out_time,
  output logic                         out_time_valid,
  output logic [$clog2(DEPTH+1)-1:0]   out_queued_count,
  output logic [31:0]                  out_queued_bytes,
  output logic [31:0]                  out_dropped_total,
  output logic signed [31:0]           out_buffered_ms
);
  import gapq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int LW = (CW > 9) ? CW : 9;

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHK       = 4'd1;  // head word in, test limits
  localparam logic [3:0] S_DROPHD    = 4'd2;  // trim: drop head, start GOP drop
  localparam logic [3:0] S_DROP_EV   = 4'd3;  // one head word dropped per cycle
  localparam logic [3:0] S_WRITE     = 4'd4;
  localparam logic [3:0] S_POP_EV    = 4'd5;
  localparam logic [3:0] S_SPAN_BK   = 4'd6;  // head word in, read back
  localparam logic [3:0] S_SPAN_CAP  = 4'd7;  // back word in, kick rescale if both times valid
  localparam logic [3:0] S_SPAN_WAIT = 4'd8;
  localparam logic [3:0] S_SPAN_END  = 4'd9;

  logic [3:0] state_r, state_nxt;

  // config
  logic [8:0]  max_pkts_r, max_pkts_nxt;
  logic [31:0] max_bytes_r, max_bytes_nxt;
  logic [30:0] live_r, live_nxt;
  logic        trim_en_r, trim_en_nxt;
  logic [30:0] num_r, num_nxt;
  logic [30:0] den_r, den_nxt;

  // queue control
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   bytes_r, bytes_nxt;
  logic [31:0]   drops_r, drops_nxt;
  logic          halted_r, halted_nxt;
  logic          trim_act_r, trim_act_nxt;
  logic          push_ctx_r, push_ctx_nxt;
  logic          flush_r, flush_nxt;
  logic          known_r, known_nxt;
  logic          out_valid_r, out_valid_nxt;

  // latched command word and result word
  desc_t         cmd_r, cmd_nxt;
  logic [47:0]   htime_r, htime_nxt;
  logic          htv_r, htv_nxt;
  logic          sneg_r, sneg_nxt;
  logic [40:0]   smag_r, smag_nxt;
  logic          res_ok_r, res_ok_nxt;
  desc_t         res_r, res_nxt;
  logic [31:0]   res_ms_r, res_ms_nxt;

  // memory and rescale hookup
  logic          we;
  logic [AW-1:0] raddr;
  desc_t         rd;
  logic          rs_start;
  logic          rs_done;
  logic          rs_neg;
  logic [40:0]   rs_mag;
  logic [48:0]   span_diff;

  logic [AW-1:0] back_ptr;
  logic [LW-1:0] lim;
  logic          cnt_full;
  logic          byte_over;
  logic [AW-1:0] head_adv;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  gapq_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (tail_r),
    .wdata (cmd_r),
    .raddr (raddr),
    .rdata (rd)
  );

  gapq_rescale u_rescale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rs_start),
    .diff  (span_diff),
    .num   (num_r),
    .den   (den_r),
    .done  (rs_done),
    .neg   (rs_neg),
    .mag   (rs_mag)
  );

  assign back_ptr  = (tail_r == '0) ? AW'(DEPTH-1) : tail_r - 1'b1;
  assign head_adv  = ptr_inc(head_r);
  assign span_diff = {rd.ts[47], rd.ts} - {htime_r[47], htime_r};

  // count limit: zero acts as one, capped at the depth
  always_comb begin
    if (max_pkts_r == 9'd0) begin
      lim = LW'(1);
    end else if (LW'(max_pkts_r) > LW'(DEPTH)) begin
      lim = LW'(DEPTH);
    end else begin
      lim = LW'(max_pkts_r);
    end
  end
  assign cnt_full  = LW'(count_r) >= lim;
  assign byte_over = (max_bytes_r != 32'd0) &&
                     (({1'b0, bytes_r} + {9'b0, cmd_r.size}) > {1'b0, max_bytes_r});

  always_comb begin
    state_nxt     = state_r;
    max_pkts_nxt  = max_pkts_r;
    max_bytes_nxt = max_bytes_r;
    live_nxt      = live_r;
    trim_en_nxt   = trim_en_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    bytes_nxt     = bytes_r;
    drops_nxt     = drops_r;
    halted_nxt    = halted_r;
    trim_act_nxt  = trim_act_r;
    push_ctx_nxt  = push_ctx_r;
    flush_nxt     = flush_r;
    known_nxt     = known_r;
    out_valid_nxt = 1'b0;
    cmd_nxt       = cmd_r;
    htime_nxt     = htime_r;
    htv_nxt       = htv_r;
    sneg_nxt      = sneg_r;
    smag_nxt      = smag_r;
    res_ok_nxt    = res_ok_r;
    res_nxt       = res_r;
    res_ms_nxt    = res_ms_r;
    we            = 1'b0;
    rs_start      = 1'b0;

    // config writes: the user makes them only while idle; the block does not enforce this
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_PKTS:  max_pkts_nxt  = cfg_data[8:0];
        CFG_MAX_BYTES: max_bytes_nxt = cfg_data;
        CFG_LIVE_MS:   live_nxt      = cfg_data[30:0];
        CFG_TRIM_EN:   trim_en_nxt   = cfg_data[0];
        CFG_TB_NUM:    num_nxt       = cfg_data[30:0];
        CFG_TB_DEN: begin
          if (cfg_data[30:0] != 31'd0) begin
            den_nxt = cfg_data[30:0];
          end
        end
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt.tag  = in_pkt_tag;
          cmd_nxt.size = in_pkt_size;
          cmd_nxt.key  = in_pkt_is_key;
          if (in_pres_time_valid) begin
            cmd_nxt.ts       = in_pres_time;
            cmd_nxt.ts_valid = 1'b1;
          end else if (in_dec_time_valid) begin
            cmd_nxt.ts       = in_dec_time;
            cmd_nxt.ts_valid = 1'b1;
          end else begin
            cmd_nxt.ts       = '0;
            cmd_nxt.ts_valid = 1'b0;
          end
          res_nxt      = '0;
          res_ok_nxt   = 1'b0;
          trim_act_nxt = 1'b0;
          state_nxt    = S_SPAN_BK;
          case (in_mode)
            MODE_PUSH: begin
              if (!halted_r) begin
                res_ok_nxt   = 1'b1;
                trim_act_nxt = trim_en_r && (live_r != 31'd0);
                state_nxt    = S_CHK;
              end
            end
            MODE_POP: begin
              if (!halted_r && (count_r != '0)) begin
                state_nxt = S_POP_EV;
              end
            end
            MODE_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
              bytes_nxt = '0;
            end
            MODE_INTR:   halted_nxt = 1'b1;
            MODE_RESUME: halted_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if ((count_r != '0) && (cnt_full || byte_over)) begin
          head_nxt     = head_adv;
          count_nxt    = count_r - 1'b1;
          bytes_nxt    = bytes_r - {8'b0, rd.size};
          drops_nxt    = drops_r + 32'd1;
          flush_nxt    = rd.key;
          push_ctx_nxt = 1'b1;
          state_nxt    = S_DROP_EV;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_DROPHD: begin
        head_nxt     = head_adv;
        count_nxt    = count_r - 1'b1;
        bytes_nxt    = bytes_r - {8'b0, rd.size};
        drops_nxt    = drops_r + 32'd1;
        flush_nxt    = rd.key;
        push_ctx_nxt = 1'b0;
        state_nxt    = S_DROP_EV;
      end
      S_DROP_EV: begin
        // key head flushes all; otherwise stop at the next keyframe
        if ((count_r != '0) && (flush_r || !rd.key)) begin
          head_nxt  = head_adv;
          count_nxt = count_r - 1'b1;
          bytes_nxt = bytes_r - {8'b0, rd.size};
          drops_nxt = drops_r + 32'd1;
        end else begin
          state_nxt = push_ctx_r ? S_CHK : S_SPAN_BK;
        end
      end
      S_WRITE: begin
        we        = 1'b1;
        tail_nxt  = ptr_inc(tail_r);
        count_nxt = count_r + 1'b1;
        bytes_nxt = bytes_r + {8'b0, cmd_r.size};
        state_nxt = S_SPAN_BK;
      end
      S_POP_EV: begin
        res_ok_nxt = 1'b1;
        res_nxt    = rd;
        head_nxt   = head_adv;
        count_nxt  = count_r - 1'b1;
        bytes_nxt  = bytes_r - {8'b0, rd.size};
        state_nxt  = S_SPAN_BK;
      end
      S_SPAN_BK: begin
        if (count_r < CW'(2)) begin
          known_nxt = 1'b0;
          state_nxt = S_SPAN_END;
        end else begin
          htime_nxt = rd.ts;
          htv_nxt   = rd.ts_valid;
          state_nxt = S_SPAN_CAP;
        end
      end
      S_SPAN_CAP: begin
        if (htv_r && rd.ts_valid) begin
          rs_start  = 1'b1;
          state_nxt = S_SPAN_WAIT;
        end else begin
          known_nxt = 1'b0;
          state_nxt = S_SPAN_END;
        end
      end
      S_SPAN_WAIT: begin
        if (rs_done) begin
          known_nxt = 1'b1;
          sneg_nxt  = rs_neg;
          smag_nxt  = rs_mag;
          state_nxt = S_SPAN_END;
        end
      end
      S_SPAN_END: begin
        if (trim_act_r && known_r && !sneg_r && (smag_r > {10'b0, live_r})) begin
          state_nxt = S_DROPHD;
        end else begin
          if (!known_r) begin
            res_ms_nxt = '0;
          end else if (!sneg_r && (smag_r > 41'h7FFF_FFFF)) begin
            res_ms_nxt = 32'h7FFF_FFFF;
          end else if (sneg_r && (smag_r > 41'h8000_0000)) begin
            res_ms_nxt = 32'h8000_0000;
          end else if (sneg_r) begin
            res_ms_nxt = 32'(-smag_r);
          end else begin
            res_ms_nxt = smag_r[31:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // back word only in S_SPAN_BK; elsewhere the head as it will stand
  assign raddr = (state_r == S_SPAN_BK) ? back_ptr : head_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_pkts_r  <= 9'd256;
      max_bytes_r <= '0;
      live_r      <= '0;
      trim_en_r   <= 1'b0;
      num_r       <= 31'd1;
      den_r       <= 31'd1000;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      bytes_r     <= '0;
      drops_r     <= '0;
      halted_r    <= 1'b0;
      trim_act_r  <= 1'b0;
      push_ctx_r  <= 1'b0;
      flush_r     <= 1'b0;
      known_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_pkts_r  <= max_pkts_nxt;
      max_bytes_r <= max_bytes_nxt;
      live_r      <= live_nxt;
      trim_en_r   <= trim_en_nxt;
      num_r       <= num_nxt;
      den_r       <= den_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      bytes_r     <= bytes_nxt;
      drops_r     <= drops_nxt;
      halted_r    <= halted_nxt;
      trim_act_r  <= trim_act_nxt;
      push_ctx_r  <= push_ctx_nxt;
      flush_r     <= flush_nxt;
      known_r     <= known_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    htime_r  <= htime_nxt;
    htv_r    <= htv_nxt;
    sneg_r   <= sneg_nxt;
    smag_r   <= smag_nxt;
    res_ok_r <= res_ok_nxt;
    res_r    <= res_nxt;
    res_ms_r <= res_ms_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_ok            = res_ok_r;
  assign out_tag           = res_r.tag;
  assign out_size          = res_r.size;
  assign out_is_key        = res_r.key;
  assign out_time          = res_r.ts;
  assign out_time_valid    = res_r.ts_valid;
  assign out_queued_count  = count_r;
  assign out_queued_bytes  = bytes_r;
  assign out_dropped_total = drops_r;
  assign out_buffered_ms   = res_ms_r;
endmodule
`default_nettype wire

@@ verif/tb_gop_aware_packet_queue.sv @@
// Self-checking testbench of the GOP-aware packet queue.
`default_nettype none
module tb_gop_aware_packet_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import gapq_pkg::*;

  localparam int QDEPTH = 256;
  localparam int IDLE_LIMIT = 200000; // worst push: 256 trim checks, each with a span rescale
  localparam logic [63:0] MS_SAT = 64'd1 << 40;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] tag;
    logic [23:0] size;
    logic        key;
    logic [47:0] pts;
    logic        pts_ok;
    logic [47:0] dts;
    logic        dts_ok;
  } cmd_t;

  typedef struct {
    logic        ok;
    logic [31:0] tag;
    logic [23:0] size;
    logic        key;
    logic [47:0] ts;
    logic        ts_ok;
    logic [8:0]  count;
    logic [31:0] bytes;
    logic [31:0] dropped;
    logic [31:0] span;
  } status_t;

  logic clk, rst_n, start, busy;
  logic [2:0] in_mode;
  logic [31:0] in_pkt_tag;
  logic [23:0] in_pkt_size;
  logic in_pkt_is_key, in_pres_time_valid, in_dec_time_valid;
  logic signed [47:0] in_pres_time, in_dec_time;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic out_valid, out_ok, out_is_key, out_time_valid;
  logic [31:0] out_tag, out_queued_bytes, out_dropped_total;
  logic [23:0] out_size;
  logic signed [47:0] out_time;
  logic [8:0] out_queued_count;
  logic signed [31:0] out_buffered_ms;

  gop_aware_packet_queue DUT (.*);

  // Shadow queue state and register copies
  logic [31:0] sh_tag [QDEPTH];
  logic [23:0] sh_size [QDEPTH];
  logic        sh_key [QDEPTH];
  logic [47:0] sh_ts [QDEPTH];
  logic        sh_ts_ok [QDEPTH];
  int unsigned sh_head, sh_tail, sh_count;
  logic [31:0] sh_bytes, sh_drops;
  logic        sh_halted;
  logic [8:0]  r_max_pkts;
  logic [31:0] r_max_bytes;
  logic [30:0] r_live_ms, r_num, r_den;
  logic        r_trim;

  cmd_t    pending_cmds[$];
  status_t expected_words[$];
  int      errors;
  int      idle_cycles;

  function automatic void queue_cmd(cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned wrap_inc(int unsigned p);
    return (p + 1 >= QDEPTH) ? 0 : p + 1;
  endfunction

  function automatic void drop_front();
    sh_bytes -= 32'(sh_size[sh_head]);
    sh_head = wrap_inc(sh_head);
    sh_count--;
    sh_drops++;
  endfunction

  // Drop up to the next keyframe, or everything if the head is one
  function automatic void drop_gop();
    if (sh_count == 0) return;
    if (sh_key[sh_head]) begin
      while (sh_count != 0) drop_front();
      return;
    end
    while (sh_count != 0 && !sh_key[sh_head]) drop_front();
  endfunction

  // Span in ms, halves away from zero, magnitude capped at 2^40
  function automatic logic span_ms(output longint ms);
    int unsigned back;
    longint diff;
    logic [63:0] mag;
    logic [127:0] prod;
    logic [127:0] quo;
    ms = 0;
    if (sh_count < 2) return 1'b0;
    back = (sh_tail == 0) ? QDEPTH - 1 : sh_tail - 1;
    if (!sh_ts_ok[sh_head] || !sh_ts_ok[back]) return 1'b0;
    diff = longint'(signed'(sh_ts[back])) - longint'(signed'(sh_ts[sh_head]));
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = 128'(mag) * (128'(r_num) * 128'(1000)) + 128'(r_den / 2);
    quo = prod / 128'(r_den);
    if (quo > 128'(MS_SAT)) quo = 128'(MS_SAT);
    ms = (diff < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    return 1'b1;
  endfunction

  function automatic void store_push(cmd_t c);
    int unsigned lim;
    longint ms;
    lim = (r_max_pkts == 0) ? 1 : ((r_max_pkts > QDEPTH) ? QDEPTH : r_max_pkts);
    while (sh_count >= lim ||
           (r_max_bytes != 0 && 33'(sh_bytes) + 33'(c.size) > 33'(r_max_bytes))) begin
      if (sh_count == 0) break;
      if (sh_key[sh_head]) begin
        drop_gop();
        break;
      end
      drop_gop();
    end
    sh_tag[sh_tail] = c.tag;
    sh_size[sh_tail] = c.size;
    sh_key[sh_tail] = c.key;
    sh_ts_ok[sh_tail] = c.pts_ok | c.dts_ok;
    sh_ts[sh_tail] = c.pts_ok ? c.pts : (c.dts_ok ? c.dts : 48'd0);
    sh_tail = wrap_inc(sh_tail);
    sh_count++;
    sh_bytes += 32'(c.size);
    if (!r_trim || r_live_ms == 0) return;
    while (sh_count >= 2) begin
      if (!span_ms(ms) || ms <= longint'(r_live_ms)) return;
      drop_gop();
    end
  endfunction

  function automatic status_t predict_status(cmd_t c);
    status_t s;
    longint ms;
    s = '{default: '0};
    case (c.mode)
      MODE_PUSH: if (!sh_halted) begin
        store_push(c);
        s.ok = 1'b1;
      end
      MODE_POP: if (!sh_halted && sh_count != 0) begin
        s.ok = 1'b1;
        s.tag = sh_tag[sh_head];
        s.size = sh_size[sh_head];
        s.key = sh_key[sh_head];
        s.ts = sh_ts[sh_head];
        s.ts_ok = sh_ts_ok[sh_head];
        sh_bytes -= 32'(sh_size[sh_head]);
        sh_head = wrap_inc(sh_head);
        sh_count--;
      end
      MODE_CLEAR: begin
        sh_head = 0;
        sh_tail = 0;
        sh_count = 0;
        sh_bytes = '0;
      end
      MODE_INTR:   sh_halted = 1'b1;
      MODE_RESUME: sh_halted = 1'b0;
      default: ;
    endcase
    s.count = 9'(sh_count);
    s.bytes = sh_bytes;
    s.dropped = sh_drops;
    if (span_ms(ms)) begin
      if (ms > 64'sd2147483647) ms = 64'sd2147483647;
      if (ms < -64'sd2147483648) ms = -64'sd2147483648;
      s.span = 32'(ms);
    end
    return s;
  endfunction

  // Driver: bursts of random length, random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    logic next_start;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      next_start = 1'b0;
      if (start) begin
        expected_words = {expected_words, predict_status(pending_cmds[0])};
        pending_cmds.delete(0);
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        in_mode <= pending_cmds[0].mode;
        in_pkt_tag <= pending_cmds[0].tag;
        in_pkt_size <= pending_cmds[0].size;
        in_pkt_is_key <= pending_cmds[0].key;
        in_pres_time <= pending_cmds[0].pts;
        in_pres_time_valid <= pending_cmds[0].pts_ok;
        in_dec_time <= pending_cmds[0].dts;
        in_dec_time_valid <= pending_cmds[0].dts_ok;
        next_start = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      start <= next_start;
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: every strobed word is checked against the oldest prediction
  always @(posedge clk) begin
    status_t e;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, got ok %0b count %0d",
                 $time, out_ok, out_queued_count);
        errors++;
      end else begin
        e = expected_words[0];
        expected_words.delete(0);
        check_field("ok", e.ok, out_ok);
        check_field("tag", e.tag, out_tag);
        check_field("size", e.size, out_size);
        check_field("is_key", e.key, out_is_key);
        check_field("time", e.ts, $unsigned(out_time));
        check_field("time_valid", e.ts_ok, out_time_valid);
        check_field("queued_count", e.count, out_queued_count);
        check_field("queued_bytes", e.bytes, out_queued_bytes);
        check_field("dropped_total", e.dropped, out_dropped_total);
        check_field("buffered_ms", e.span, $unsigned(out_buffered_ms));
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_gop_aware_packet_queue: FAIL");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_PKTS:  r_max_pkts = val[8:0];
      CFG_MAX_BYTES: r_max_bytes = val;
      CFG_LIVE_MS:   r_live_ms = val[30:0];
      CFG_TRIM_EN:   r_trim = val[0];
      CFG_TB_NUM:    r_num = val[30:0];
      CFG_TB_DEN:    if (val[30:0] != 0) r_den = val[30:0];
      default: ;
    endcase
  endtask

  // Drain before touching registers; the sender holds off meanwhile
  task automatic set_regs(logic [8:0] pk, logic [31:0] by, logic [30:0] lm, logic tr,
                          logic [30:0] nu, logic [30:0] de);
    wait (pending_cmds.size() == 0 && !start && expected_words.size() == 0);
    repeat (5) @(posedge clk);
    cfg_write(CFG_MAX_PKTS, 32'(pk));
    cfg_write(CFG_MAX_BYTES, by);
    cfg_write(CFG_LIVE_MS, 32'(lm));
    cfg_write(CFG_TRIM_EN, 32'(tr));
    cfg_write(CFG_TB_NUM, 32'(nu));
    cfg_write(CFG_TB_DEN, 32'(de));
  endtask

  function automatic cmd_t mk(logic [2:0] m, logic [31:0] tg, logic [23:0] sz, logic k,
                              logic [47:0] p, logic pv, logic [47:0] d, logic dv);
    cmd_t c;
    c = '{m, tg, sz, k, p, pv, d, dv};
    return c;
  endfunction

  function automatic cmd_t mk_op(logic [2:0] m);
    return mk(m, $urandom, 24'($urandom), 1'($urandom), {$urandom, $urandom}, 1'($urandom),
              {$urandom, $urandom}, 1'($urandom));
  endfunction

  // Random GOP-shaped traffic with some noise and broken sequences
  longint ts_now;
  int gop_left;
  task automatic gen_traffic(int n, int unsigned step, int unsigned max_sz);
    int r;
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        c = mk_op(MODE_PUSH);
        c.key = (gop_left == 0);
        gop_left = (gop_left == 0) ? $urandom_range(0, 7) : gop_left - 1;
        ts_now += $urandom_range(0, step);
        c.pts = 48'(ts_now);
        c.dts = 48'(ts_now - $urandom_range(0, 3));
        c.pts_ok = ($urandom_range(0, 9) != 0);
        c.dts_ok = ($urandom_range(0, 2) != 0);
        c.size = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, max_sz));
      end else if (r < 82) begin
        c = mk_op(MODE_POP);
      end else if (r < 85) begin
        c = mk_op(MODE_CLEAR);
      end else if (r < 89) begin
        queue_cmd(mk_op(MODE_INTR));
        repeat ($urandom_range(0, 3))
          queue_cmd(mk_op($urandom_range(0, 1) ? MODE_PUSH : MODE_POP));
        c = mk_op(MODE_RESUME);
      end else if (r < 92) begin
        c = mk_op(3'($urandom_range(5, 7)));
      end else begin
        c = mk_op(MODE_PUSH); // fully random descriptor
      end
      queue_cmd(c);
    end
  endtask

  initial begin
    errors = 0;
    ts_now = 0;
    gop_left = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    in_mode = MODE_PUSH;
    in_pkt_tag = '0;
    in_pkt_size = '0;
    in_pkt_is_key = 1'b0;
    in_pres_time = '0;
    in_pres_time_valid = 1'b0;
    in_dec_time = '0;
    in_dec_time_valid = 1'b0;
    sh_head = 0;
    sh_tail = 0;
    sh_count = 0;
    sh_bytes = '0;
    sh_drops = '0;
    sh_halted = 1'b0;
    r_max_pkts = 9'd256;
    r_max_bytes = '0;
    r_live_ms = '0;
    r_trim = 1'b0;
    r_num = 31'd1;
    r_den = 31'd1000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset settings: empty pop, extremes, timestamp fallbacks
    queue_cmd(mk(MODE_POP, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(MODE_PUSH, '1, '1, 1, 48'h7FFF_FFFF_FFFF, 1, 0, 0));
    queue_cmd(mk(MODE_PUSH, 0, 0, 0, 48'h8000_0000_0000, 1, 0, 0));
    queue_cmd(mk(MODE_PUSH, 32'h5a5a, 24'h10, 0, 0, 0, 48'hFFFF_FFFF_FF00, 1));
    queue_cmd(mk(MODE_PUSH, 32'ha5a5, 24'h20, 0, '1, 0, '1, 0));
    queue_cmd(mk(MODE_PUSH, 32'h1, 24'h1, 1, 48'd500, 1, 48'd400, 1));
    queue_cmd(mk(MODE_POP, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(MODE_INTR, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(MODE_PUSH, 7, 7, 1, 7, 1, 7, 1));
    queue_cmd(mk(MODE_POP, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(MODE_RESUME, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(3'd5, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(3'd6, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(3'd7, '1, '1, 1, '1, 1, '1, 1));
    queue_cmd(mk(MODE_PUSH, 2, 5, 1, 48'd0, 1, 0, 0));
    queue_cmd(mk(MODE_PUSH, 3, 5, 0, 48'd10, 1, 0, 0));
    queue_cmd(mk(MODE_POP, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk(MODE_POP, 0, 0, 0, 0, 0, 0, 0));

    // Count limit of one, byte limit tiny: oversize packet stored alone
    set_regs(9'd1, 32'd100, 31'd0, 1'b0, 31'd1, 31'd1000);
    queue_cmd(mk(MODE_PUSH, 10, 24'hFF_FFFF, 0, 0, 1, 0, 0));
    queue_cmd(mk(MODE_PUSH, 11, 24'd50, 1, 5, 1, 0, 0));
    queue_cmd(mk(MODE_PUSH, 12, 24'd60, 0, 9, 1, 0, 0));
    gen_traffic(30, 20, 80);

    // Span trimming, millisecond time base
    set_regs(9'd8, 32'd0, 31'd100, 1'b1, 31'd1, 31'd1000);
    gen_traffic(70, 40, 5000);

    // Byte limit with GOP drops
    set_regs(9'd256, 32'd20000, 31'd0, 1'b0, 31'd1, 31'd1000);
    gen_traffic(60, 30, 3000);

    // Huge time base: spans saturate; maximum byte and span limits
    set_regs(9'd256, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, 31'd1);
    gen_traffic(50, 1000, 1 << 23);

    // Fine time base with rounding, denominator at its top, a zero write ignored
    set_regs(9'd5, 32'd0, 31'd1, 1'b1, 31'd90001, 31'h7FFF_FFFF);
    cfg_write(CFG_TB_DEN, 32'd0);
    gen_traffic(50, 50000, 1000);

    // Zero numerator: span always zero; small limit trims never fire
    set_regs(9'd3, 32'd0, 31'd1, 1'b1, 31'd0, 31'd7);
    gen_traffic(40, 100, 1000);

    // No byte limit and the count limit at the depth, with big packets
    set_regs(9'd256, 32'd0, 31'd0, 1'b0, 31'd3, 31'd90000);
    gen_traffic(100, 3000, 24'hFF_FFFF);

    wait (pending_cmds.size() == 0 && !start && expected_words.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_gop_aware_packet_queue: PASS");
    end else begin
      $display("tb_gop_aware_packet_queue: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/gapq_pkg.sv
hw/rtl/gapq_store.sv
hw/rtl/gapq_rescale.sv
hw/rtl/gop_aware_packet_queue.sv
verif/tb_gop_aware_packet_queue.sv
